// ----- sv/tcw_pkg.sv -----
// Shared constants, command codes and cursor interface types for the text console.
package tcw_pkg;

  localparam int unsigned SCREEN_COLS    = 80;
  localparam int unsigned SCREEN_ROWS    = 25;
  localparam int unsigned CELL_COUNT     = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned MOVE_COUNT     = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int unsigned LAST_ROW_START = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int unsigned TAB_STEP       = 8;

  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
  localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
  localparam int unsigned COL_XW = (COL_W > 7) ? COL_W : 7;
  localparam int unsigned ROW_XW = (ROW_W > 5) ? ROW_W : 5;
  localparam int unsigned CELL_W = 16;

  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR  = 8'h07;

  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_RAW   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic put;
    logic set;
    logic home;
  } cur_ctl_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] pos;
    logic              wrap;
  } cur_stat_t;

endpackage

// ----- sv/tcw_ram.sv -----
// Simple dual-port screen cell memory with registered read data.
module tcw_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- sv/tcw_cursor.sv -----
// Cursor registers with clamping, advance, tab, newline and wrap detection.
module tcw_cursor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::cur_ctl_t  ctl_i,
  input  logic [7:0]         char_code_i,
  input  logic [6:0]         col_i,
  input  logic [4:0]         row_i,
  output tcw_pkg::cur_stat_t stat_o
);

  import tcw_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [COL_W-1:0]  col_c;
  logic [ROW_W-1:0]  row_c;
  logic [ADDR_W-1:0] pos;
  logic [3:0]        step;
  logic [COL_W:0]    col_sum;
  logic [ADDR_W-1:0] delta;
  logic              new_row;
  logic              wrap;
  logic [COL_W-1:0]  col_adv;

  always_comb begin
    col_c = (32'(col_i) > SCREEN_COLS - 1) ? COL_W'(SCREEN_COLS - 1) : COL_W'(col_i);
    row_c = (32'(row_i) > SCREEN_ROWS - 1) ? ROW_W'(SCREEN_ROWS - 1) : ROW_W'(row_i);
    pos   = ADDR_W'(32'(row_c) * SCREEN_COLS + 32'(col_c));
  end

  always_comb begin
    step    = 4'(TAB_STEP) - {1'b0, off_q[2:0]};
    col_sum = '0;
    delta   = ADDR_W'(1);
    new_row = 1'b0;
    if (char_code_i == CHR_NEWLINE) begin
      new_row = 1'b1;
      delta   = ADDR_W'(SCREEN_COLS) - ADDR_W'(col_q);
    end else begin
      if (char_code_i == CHR_TAB) begin
        col_sum = (COL_W+1)'(col_q) + (COL_W+1)'(step);
        delta   = ADDR_W'(step);
      end else begin
        col_sum = (COL_W+1)'(col_q) + (COL_W+1)'(1);
      end
      if (col_sum >= (COL_W+1)'(SCREEN_COLS)) begin
        new_row = 1'b1;
        col_sum = col_sum - (COL_W+1)'(SCREEN_COLS);
      end
    end
    col_adv = col_sum[COL_W-1:0];
    wrap    = new_row && (row_q == ROW_W'(SCREEN_ROWS - 1));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    off_d = off_q;
    if (ctl_i.home) begin
      col_d = '0;
      row_d = '0;
      off_d = '0;
    end else if (ctl_i.set) begin
      col_d = col_c;
      row_d = row_c;
      off_d = pos;
    end else if (ctl_i.put) begin
      if (wrap) begin
        col_d = '0;
        row_d = ROW_W'(SCREEN_ROWS - 1);
        off_d = ADDR_W'(LAST_ROW_START);
      end else begin
        col_d = col_adv;
        row_d = new_row ? row_q + ROW_W'(1) : row_q;
        off_d = off_q + delta;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      off_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      off_q <= off_d;
    end
  end

  assign stat_o = '{col: col_q, row: row_q, off: off_q, pos: pos, wrap: wrap};

endmodule

// ----- sv/text_console_cell_writer.sv -----
// Character-cell text console: command sequencer, screen memory and result register.
// For put, set, raw write and read, ST_IDLE takes the transfer and accesses the memory, and
// ST_FINISH loads the result register once any earlier result has been taken; the input is
// not ready outside ST_IDLE, so a new item is taken only after the last result is loaded.
// A scroll moves rows up, then ST_FILL blanks the last row; a clear blanks all cells.
// Reset: after reset a clearing pass writes spaces with attribute 7 to all 2000 cells,
// one cell per cycle, with the input held not ready; configuration writes are taken meanwhile.
module text_console_cell_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] col_i,
  input  logic [4:0] row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o
);

  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              is_read_q, is_read_d;
  logic              out_valid_q, out_valid_d;
  logic [6:0]        cursor_col_q, cursor_col_d;
  logic [4:0]        cursor_row_q, cursor_row_d;
  logic [7:0]        cell_char_q, cell_char_d;
  logic [7:0]        cell_attr_q, cell_attr_d;
  logic [7:0]        text_attribute_q;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  cur_ctl_t          cur_ctl;
  cur_stat_t         cur_stat;
  logic [COL_XW-1:0] col_x;
  logic [ROW_XW-1:0] row_x;

  tcw_ram #(
    .Depth(CELL_COUNT),
    .Width(CELL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tcw_cursor u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cur_ctl),
    .char_code_i(char_code_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .stat_o     (cur_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attribute_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      text_attribute_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign col_x      = COL_XW'(cur_stat.col);
  assign row_x      = ROW_XW'(cur_stat.row);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    is_read_d    = is_read_q;
    out_valid_d  = out_valid_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    cell_char_d  = cell_char_q;
    cell_attr_d  = cell_attr_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_stat.off;
    ram_wdata    = {text_attribute_q, char_code_i};
    ram_re       = 1'b0;
    ram_raddr    = cur_stat.pos;
    cur_ctl      = '0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {RESET_ATTR, CHR_SPACE};
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          is_read_d = 1'b0;
          state_d   = ST_FINISH;
          cnt_d     = '0;
          case (cmd_e'(command_i))
            CMD_PUT: begin
              cur_ctl.put = 1'b1;
              ram_we      = (char_code_i != CHR_NEWLINE) && (char_code_i != CHR_TAB);
              if (cur_stat.wrap) begin
                state_d = ST_SCROLL;
              end
            end
            CMD_SET: begin
              cur_ctl.set = 1'b1;
            end
            CMD_CLEAR: begin
              cur_ctl.home = 1'b1;
              state_d      = ST_FILL;
            end
            CMD_RAW: begin
              ram_we    = 1'b1;
              ram_waddr = cur_stat.pos;
            end
            CMD_READ: begin
              ram_re    = 1'b1;
              is_read_d = 1'b1;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        ram_re    = (cnt_q != ADDR_W'(MOVE_COUNT));
        ram_raddr = cnt_q + ADDR_W'(SCREEN_COLS);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt_q == ADDR_W'(MOVE_COUNT)) begin
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {text_attribute_q, CHR_SPACE};
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          cursor_col_d = col_x[6:0];
          cursor_row_d = row_x[4:0];
          cell_char_d  = is_read_q ? ram_rdata[7:0] : 8'h00;
          cell_attr_d  = is_read_q ? ram_rdata[15:8] : 8'h00;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      is_read_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      cell_char_q  <= '0;
      cell_attr_q  <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      is_read_q    <= is_read_d;
      out_valid_q  <= out_valid_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      cell_char_q  <= cell_char_d;
      cell_attr_q  <= cell_attr_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = cursor_col_q;
  assign cursor_row_o = cursor_row_q;
  assign cell_char_o  = cell_char_q;
  assign cell_attr_o  = cell_attr_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("memory read and write collide on one cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_stat.off < ADDR_W'(CELL_COUNT))
    else $error("cursor offset past the last cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_stat.off) == 32'(cur_stat.row) * SCREEN_COLS + 32'(cur_stat.col))
    else $error("cursor offset disagrees with row and column");
`endif

endmodule

// ----- dv/text_console_cell_writer_tb.sv -----
// Self-checking testbench for the text console cell writer: directed edge cases plus random traffic.
module text_console_cell_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [7:0] CHR_LETTER_A = 8'h41;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic [7:0] ch;
    logic [7:0] attr;
  } console_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [2:0] command_i   = 3'd0;
  logic [7:0] char_code_i = 8'h00;
  logic [6:0] col_i       = 7'd0;
  logic [4:0] row_i       = 5'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [6:0] cursor_col_o;
  logic [4:0] cursor_row_o;
  logic [7:0] cell_char_o;
  logic [7:0] cell_attr_o;

  // console shadow state
  logic [15:0] screen_shadow [CELL_COUNT];
  int unsigned cursor_shadow;
  logic [7:0]  attr_shadow;

  console_result_t pending_results[$];
  bit idle_on = 1'b1;

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned put_count;
  int unsigned scroll_count;
  int unsigned clear_count;
  int unsigned read_count;
  int unsigned clamp_count;
  int unsigned attr_writes;

  text_console_cell_writer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("timeout: %0d transfers sent, %0d results seen", items_sent, results_seen);
    $display("simulation failed");
    $finish;
  end

  function automatic console_result_t console_step(input logic [2:0] cmd, input logic [7:0] ch,
                                                   input logic [6:0] col, input logic [4:0] row);
    console_result_t res;
    int unsigned off;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    res = '0;
    c = (col > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : col;
    r = (row > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : row;
    idx = r * SCREEN_COLS + c;
    if ((cmd == CMD_SET || cmd == CMD_RAW || cmd == CMD_READ) &&
        (col > SCREEN_COLS - 1 || row > SCREEN_ROWS - 1)) begin
      clamp_count++;
    end
    case (cmd)
      CMD_PUT: begin
        put_count++;
        off = cursor_shadow;
        if (ch == CHR_NEWLINE) begin
          off += SCREEN_COLS - (off % SCREEN_COLS);
        end else if (ch == CHR_TAB) begin
          off += TAB_STEP - (off % TAB_STEP);
        end else begin
          screen_shadow[off] = {attr_shadow, ch};
          off++;
        end
        if (off >= CELL_COUNT) begin
          for (int unsigned i = 0; i < MOVE_COUNT; i++) begin
            screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
          end
          for (int unsigned i = LAST_ROW_START; i < CELL_COUNT; i++) begin
            screen_shadow[i] = {attr_shadow, CHR_SPACE};
          end
          off = LAST_ROW_START;
          scroll_count++;
        end
        cursor_shadow = off;
      end
      CMD_SET: begin
        cursor_shadow = idx;
      end
      CMD_CLEAR: begin
        for (int unsigned i = 0; i < CELL_COUNT; i++) begin
          screen_shadow[i] = {attr_shadow, CHR_SPACE};
        end
        cursor_shadow = 0;
        clear_count++;
      end
      CMD_RAW: begin
        screen_shadow[idx] = {attr_shadow, ch};
      end
      CMD_READ: begin
        res.ch   = screen_shadow[idx][7:0];
        res.attr = screen_shadow[idx][15:8];
        read_count++;
      end
      default: begin
      end
    endcase
    res.cur_col = 7'(cursor_shadow % SCREEN_COLS);
    res.cur_row = 5'(cursor_shadow / SCREEN_COLS);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    end
    mismatch_count++;
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                          input logic [6:0] col, input logic [4:0] row);
    if (idle_on && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    char_code_i <= ch;
    col_i       <= col;
    row_i       <= row;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(console_step(cmd, ch, col, row));
    items_sent++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic write_attribute(input logic [7:0] value);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    attr_shadow = value;
    attr_writes++;
  endtask

  task automatic test_reset_contents();
    send_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_READ, 8'hFF, 7'd127, 5'd31);
    send_cmd(CMD_PUT, CHR_LETTER_A, 7'd0, 5'd0);
    send_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    stop_sending();
  endtask

  task automatic test_cursor_and_scroll();
    write_attribute(8'hFF);
    send_cmd(CMD_SET, 8'h00, 7'd127, 5'd31);
    send_cmd(CMD_READ, 8'h00, 7'd127, 5'd31);
    send_cmd(CMD_RAW, 8'hFF, 7'd127, 5'd31);
    send_cmd(CMD_READ, 8'h00, 7'd79, 5'd24);
    send_cmd(CMD_PUT, 8'hFF, 7'd0, 5'd0);
    send_cmd(CMD_READ, 8'h00, 7'd79, 5'd23);
    send_cmd(CMD_READ, 8'h00, 7'd0, 5'd24);
    send_cmd(CMD_SET, 8'h00, 7'd72, 5'd24);
    send_cmd(CMD_PUT, CHR_TAB, 7'd0, 5'd0);
    send_cmd(CMD_SET, 8'h00, 7'd5, 5'd24);
    send_cmd(CMD_PUT, CHR_NEWLINE, 7'd0, 5'd0);
    send_cmd(CMD_PUT, 8'h00, 7'd0, 5'd0);
    stop_sending();
  endtask

  task automatic test_clear_and_spare();
    write_attribute(8'h00);
    send_cmd(CMD_CLEAR, 8'hFF, 7'd127, 5'd31);
    send_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_SPARE_LO, 8'h5A, 7'd33, 5'd17);
    send_cmd(3'(CMD_SPARE_LO + 1), 8'hA5, 7'd127, 5'd31);
    send_cmd(CMD_SPARE_HI, 8'hFF, 7'd64, 5'd16);
    send_cmd(CMD_RAW, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_READ, 8'hFF, 7'd0, 5'd0);
    send_cmd(CMD_PUT, CHR_NEWLINE, 7'd0, 5'd0);
    send_cmd(CMD_PUT, CHR_TAB, 7'd0, 5'd0);
    stop_sending();
  endtask

  task automatic run_mixed_traffic(input int count);
    int pick;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom_range(0, 255));
      col  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, SCREEN_COLS - 1));
      row  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, SCREEN_ROWS - 1));
      if (pick < 8) begin
        ch = CHR_NEWLINE;
      end else if (pick < 12) begin
        ch = CHR_TAB;
      end
      if (pick < 50) begin
        send_cmd(CMD_PUT, ch, col, row);
      end else if (pick < 58) begin
        send_cmd(CMD_SET, ch, col, row);
      end else if (pick < 63) begin
        send_cmd(CMD_SET, ch, col, 5'(SCREEN_ROWS - 1));
      end else if (pick < 72) begin
        send_cmd(CMD_RAW, ch, col, row);
      end else if (pick < 88) begin
        send_cmd(CMD_READ, ch, col, row);
      end else if (pick < 91) begin
        send_cmd(CMD_CLEAR, ch, col, row);
      end else if (pick < 94) begin
        send_cmd(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), ch, col, row);
      end else begin
        send_cmd(CMD_READ, ch, col, 5'(SCREEN_ROWS - 1));
      end
    end
    stop_sending();
  endtask

  task automatic test_random_bright();
    write_attribute(8'($urandom_range(1, 254)));
    run_mixed_traffic(350);
  endtask

  task automatic test_random_dark();
    write_attribute(8'h80);
    run_mixed_traffic(250);
  endtask

  task automatic test_back_to_back();
    write_attribute(8'($urandom_range(0, 255)));
    idle_on = 1'b0;
    run_mixed_traffic(100);
  endtask

  // result checker
  always @(posedge clk_i) begin : result_monitor
    console_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result col %0d row %0d", cursor_col_o,
                                cursor_row_o));
      end else begin
        want = pending_results.pop_front();
        if (cursor_col_o !== want.cur_col) begin
          flag_mismatch($sformatf("cursor_col %0d, expected %0d", cursor_col_o, want.cur_col));
        end
        if (cursor_row_o !== want.cur_row) begin
          flag_mismatch($sformatf("cursor_row %0d, expected %0d", cursor_row_o, want.cur_row));
        end
        if (cell_char_o !== want.ch) begin
          flag_mismatch($sformatf("cell_char %0h, expected %0h", cell_char_o, want.ch));
        end
        if (cell_attr_o !== want.attr) begin
          flag_mismatch($sformatf("cell_attr %0h, expected %0h", cell_attr_o, want.attr));
        end
      end
      results_seen++;
    end
  end

  // receiver backpressure
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 99) < 35) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    for (int unsigned i = 0; i < CELL_COUNT; i++) begin
      screen_shadow[i] = {RESET_ATTR, CHR_SPACE};
    end
    cursor_shadow = 0;
    attr_shadow   = RESET_ATTR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_cursor_and_scroll();
    test_clear_and_spare();
    test_random_bright();
    test_random_dark();
    test_back_to_back();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d transfers: %0d puts, %0d scrolls, %0d clears, %0d reads",
             items_sent, put_count, scroll_count, clear_count, read_count);
    $display("%0d clamped coordinates, %0d attribute writes, %0d results checked",
             clamp_count, attr_writes, results_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
